// ----- design/sstor_pkg.sv -----
// Shared types and codes for the sorted set reader.
`default_nettype none
package sstor_pkg;
  typedef enum logic [2:0] {
    CMD_INSERT     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_READ_ASC   = 3'd2,
    CMD_READ_SIDE  = 3'd3,
    CMD_READ_PRIME = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SHIFT,
    S_WALK,
    S_DONE
  } state_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic        ins;      // open a slot and insert
    logic        rem;      // close the slot of a match
    logic        rot;      // rotate chain by one towards cell zero
    logic [31:0] value;
    logic        prime;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ----- design/sstor_cell.sv -----
// One cell of the sorted chain: a value, a prime flag and a valid bit.
`default_nettype none
module sstor_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire sstor_pkg::cell_ctl_t ctl,
  input  wire                  lo_valid,   // neighbour below
  input  wire                  lo_less,    // neighbour below holds a value < ctl.value (high at the bottom)
  input  wire                  lo_gone,    // removal point lies at or below the neighbour
  input  wire  [31:0]          lo_value,
  input  wire                  lo_prime,
  input  wire                  hi_valid,   // neighbour above
  input  wire  [31:0]          hi_value,
  input  wire                  hi_prime,
  input  wire                  wrap_valid, // rotate feed
  input  wire  [31:0]          wrap_value,
  input  wire                  wrap_prime,
  output logic                 valid,
  output logic [31:0]          value,
  output logic                 prime,
  output logic                 less,
  output logic                 gone
);
  logic        valid_r, valid_nxt;
  logic [31:0] value_r, value_nxt;
  logic        prime_r, prime_nxt;

  assign less = valid_r && ($signed(value_r) < $signed(ctl.value));
  assign gone = lo_gone || (valid_r && value_r == ctl.value);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prime_nxt = prime_r;
    if (ctl.ins) begin
      if (!less) begin
        if (lo_less) begin
          // first cell not below the new value: take it here
          value_nxt = ctl.value;
          prime_nxt = ctl.prime;
          valid_nxt = 1'b1;
        end else begin
          value_nxt = lo_value;
          prime_nxt = lo_prime;
          valid_nxt = lo_valid;
        end
      end
    end else if (ctl.rem) begin
      if (gone) begin
        value_nxt = hi_value;
        prime_nxt = hi_prime;
        valid_nxt = hi_valid;
      end
    end else if (ctl.rot) begin
      value_nxt = wrap_value;
      prime_nxt = wrap_prime;
      valid_nxt = wrap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    prime_r <= prime_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign prime = prime_r;
endmodule
`default_nettype wire

// ----- design/sstor_prime.sv -----
// Trial-division primality unit; each divisor is tried by bit-serial restoring division.
`default_nettype none
module sstor_prime (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [31:0] value,
  output logic        done,
  output logic        is_prime
);
  logic        busy_r, busy_nxt;
  logic [31:0] n_r, n_nxt;
  logic [16:0] d_r, d_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic        done_r, done_nxt;
  logic        res_r, res_nxt;
  logic [33:0] dsq;
  logic [32:0] trial;

  assign dsq = {17'd0, d_r} * {17'd0, d_r};
  assign trial = {rem_r, n_r[bit_r]} - {16'd0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    n_nxt = n_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    if (start) begin
      n_nxt = value;
      d_nxt = 17'd2;
      rem_nxt = '0;
      bit_nxt = 5'd31;
      if ($signed(value) <= 32'sd1) begin
        res_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (bit_r == 5'd31 && rem_r == '0 && dsq > {2'd0, n_r}) begin
        // no divisor up to the root
        busy_nxt = 1'b0;
        res_nxt = 1'b1;
        done_nxt = 1'b1;
      end else begin
        if (!trial[32]) rem_nxt = trial[31:0];
        else rem_nxt = {rem_r[30:0], n_r[bit_r]};
        if (bit_r == 5'd0) begin
          bit_nxt = 5'd31;
          if ((!trial[32] ? trial[31:0] : {rem_r[30:0], n_r[0]}) == '0) begin
            busy_nxt = 1'b0;
            res_nxt = 1'b0;
            done_nxt = 1'b1;
          end
          rem_nxt = '0;
          d_nxt = d_r + 17'd1;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r <= n_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign is_prime = res_r;
endmodule
`default_nettype wire

// ----- design/sorted_set_three_order_reader.sv -----
// Top level of the sorted set with prime filter.
// Holds up to DEPTH distinct signed values in ascending order in a chain of cells, each
// with its own value, prime flag and valid bit. One request is handled at a time. Insert
// first checks for a duplicate and a full store in the shift state, then runs trial
// division (a bit-serial divide per divisor, so a large prime takes far longer than a
// small value or a composite), then opens a slot. Remove closes its slot in the shift
// state. Reads rotate the chain one cell per cycle, DEPTH steps round the whole ring, and
// pick the entry as it passes cell zero, so a read or prime read offers its result after
// the walk; a remove, a rejected insert, an unused code or a size query offers it straight
// after the shift state. The result is held in an output register until taken, and the
// next request is taken no earlier than the cycle after that.
`default_nettype none
module sorted_set_three_order_reader #(
  parameter int DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_command,
  input  wire  [31:0] in_value,
  input  wire  [5:0]  in_position,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_element_count,
  output logic [6:0]  out_prime_count
);
  localparam int CW = $clog2(DEPTH + 1);

  sstor_pkg::state_t state_r, state_nxt;
  sstor_pkg::cell_ctl_t ctl;

  logic [2:0]  cmd_r;
  logic [31:0] val_r;
  logic [5:0]  pos_r;
  logic [CW-1:0] cnt_r, cnt_nxt, pcnt_r, pcnt_nxt;
  logic [CW-1:0] step_r, step_nxt;   // rotation step
  logic [CW-1:0] pk_r, pk_nxt;       // primes seen so far
  logic [CW-1:0] tgt_r;              // target ascending index
  logic [31:0] rd_r, rd_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        pstart, pdone, pres;

  logic [DEPTH-1:0] c_valid, c_prime, c_less, c_gone;
  logic [31:0]      c_value [DEPTH];

  logic dup_hit, found;
  assign dup_hit = |(c_gone & c_valid) || c_gone[DEPTH-1];
  assign found = c_gone[DEPTH-1];

  // The bottom cell sees an imaginary smaller neighbour, so it takes a new minimum.
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sstor_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .lo_valid  (g == 0 ? 1'b0  : c_valid[(g == 0) ? 0 : g-1]),
        .lo_less   (g == 0 ? 1'b1  : c_less[(g == 0) ? 0 : g-1]),
        .lo_gone   (g == 0 ? 1'b0  : c_gone[(g == 0) ? 0 : g-1]),
        .lo_value  (c_value[(g == 0) ? 0 : g-1]),
        .lo_prime  (g == 0 ? 1'b0  : c_prime[(g == 0) ? 0 : g-1]),
        .hi_valid  (g == DEPTH-1 ? 1'b0 : c_valid[(g == DEPTH-1) ? g : g+1]),
        .hi_value  (c_value[(g == DEPTH-1) ? g : g+1]),
        .hi_prime  (c_prime[(g == DEPTH-1) ? g : g+1]),
        .wrap_valid(c_valid[(g == DEPTH-1) ? 0 : g+1]),
        .wrap_value(c_value[(g == DEPTH-1) ? 0 : g+1]),
        .wrap_prime(c_prime[(g == DEPTH-1) ? 0 : g+1]),
        .valid     (c_valid[g]),
        .value     (c_value[g]),
        .prime     (c_prime[g]),
        .less      (c_less[g]),
        .gone      (c_gone[g])
      );
    end
  endgenerate

  sstor_prime u_prime (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pstart),
    .value   (val_r),
    .done    (pdone),
    .is_prime(pres)
  );

  logic acc;
  assign acc = in_valid && in_ready;
  assign in_ready = (state_r == sstor_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sstor_pkg::S_IDLE:  if (acc) state_nxt = sstor_pkg::S_SHIFT;
      sstor_pkg::S_SHIFT: begin
        if (cmd_r == sstor_pkg::CMD_INSERT && !dup_hit && cnt_r < CW'(DEPTH))
          state_nxt = sstor_pkg::S_PRIME;
        else if (cmd_r == sstor_pkg::CMD_READ_ASC || cmd_r == sstor_pkg::CMD_READ_SIDE ||
                 cmd_r == sstor_pkg::CMD_READ_PRIME)
          state_nxt = sstor_pkg::S_WALK;
        else state_nxt = sstor_pkg::S_DONE;
      end
      sstor_pkg::S_PRIME: if (pdone) state_nxt = sstor_pkg::S_DONE;
      sstor_pkg::S_WALK:  if (step_r == CW'(DEPTH - 1)) state_nxt = sstor_pkg::S_DONE;
      sstor_pkg::S_DONE:  if (out_ready) state_nxt = sstor_pkg::S_IDLE;
      default:            state_nxt = sstor_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath
  logic in_range;
  always_comb begin
    ctl = '0;
    ctl.value = val_r;
    ctl.prime = pres;
    pstart = 1'b0;
    cnt_nxt = cnt_r;
    pcnt_nxt = pcnt_r;
    step_nxt = step_r;
    pk_nxt = pk_r;
    rd_nxt = rd_r;
    st_nxt = st_r;
    in_range = 1'b0;
    unique case (state_r)
      sstor_pkg::S_IDLE: begin
        step_nxt = '0;
        pk_nxt = '0;
        rd_nxt = '0;
        st_nxt = sstor_pkg::ST_OK;
      end
      sstor_pkg::S_SHIFT: begin
        case (cmd_r)
          sstor_pkg::CMD_INSERT: begin
            if (dup_hit) st_nxt = sstor_pkg::ST_DUP;
            else if (cnt_r >= CW'(DEPTH)) st_nxt = sstor_pkg::ST_FULL;
            else pstart = 1'b1;
          end
          sstor_pkg::CMD_REMOVE: begin
            if (found) begin
              ctl.rem = 1'b1;
              cnt_nxt = cnt_r - CW'(1);
              if (|(c_gone & ~{c_gone[DEPTH-2:0], 1'b0} & c_prime))
                pcnt_nxt = pcnt_r - CW'(1);
            end else st_nxt = sstor_pkg::ST_NOTFOUND;
          end
          sstor_pkg::CMD_READ_ASC, sstor_pkg::CMD_READ_SIDE: begin
            in_range = {{(CW > 6 ? CW-6 : 0){1'b0}}, pos_r} < cnt_r;
            if (!in_range) st_nxt = sstor_pkg::ST_RANGE;
          end
          sstor_pkg::CMD_READ_PRIME: begin
            in_range = {{(CW > 6 ? CW-6 : 0){1'b0}}, pos_r} < pcnt_r;
            if (!in_range) st_nxt = sstor_pkg::ST_RANGE;
          end
          default: ;
        endcase
      end
      sstor_pkg::S_PRIME: begin
        if (pdone) begin
          ctl.ins = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          if (pres) pcnt_nxt = pcnt_r + CW'(1);
        end
      end
      sstor_pkg::S_WALK: begin
        // advance the ring; cell zero shows ascending entry step_r
        ctl.rot = 1'b1;
        step_nxt = step_r + CW'(1);
        if (st_r == sstor_pkg::ST_OK && step_r < cnt_r) begin
          if (cmd_r == sstor_pkg::CMD_READ_PRIME) begin
            if (c_prime[0]) begin
              if (pk_r == {{(CW > 6 ? CW-6 : 0){1'b0}}, pos_r}) rd_nxt = c_value[0];
              pk_nxt = pk_r + CW'(1);
            end
          end else if (step_r == tgt_r) rd_nxt = c_value[0];
        end
      end
      sstor_pkg::S_DONE: ;
      default: ;
    endcase
  end

  logic [CW-1:0] half;
  assign half = CW'(pos_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstor_pkg::S_IDLE;
      cnt_r <= '0;
      pcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pcnt_r <= pcnt_nxt;
    end
    if (acc) begin
      cmd_r <= in_command;
      val_r <= in_value;
      pos_r <= in_position;
    end
    // ascending reads aim at the position itself; side-cross alternates the two ends
    if (state_r == sstor_pkg::S_SHIFT)
      tgt_r <= (cmd_r == sstor_pkg::CMD_READ_ASC) ? CW'(pos_r) :
               (pos_r[0] ? cnt_r - CW'(1) - half : half);
    step_r <= step_nxt;
    pk_r <= pk_nxt;
    rd_r <= rd_nxt;
    st_r <= st_nxt;
  end

  assign out_valid = (state_r == sstor_pkg::S_DONE);
  assign out_status = st_r;
  assign out_read_value = rd_r;
  assign out_element_count = 7'(cnt_r);
  assign out_prime_count = 7'(pcnt_r);
endmodule
`default_nettype wire

// ----- design/sstor_checker.sv -----
// Port-level checker for the sorted set reader, bound to the top level.
`default_nettype none
module sstor_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_status,
  input wire [31:0] out_read_value,
  input wire [6:0]  out_element_count,
  input wire [6:0]  out_prime_count
);
  a_primes_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_prime_count <= out_element_count) else $error("primes exceed count");
  a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sstor_pkg::ST_OK |-> out_read_value == 32'd0)
    else $error("value on error");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)) else $error("result dropped");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second request taken while busy");
endmodule

bind sorted_set_three_order_reader sstor_checker u_sstor_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_read_value(out_read_value), .out_element_count(out_element_count),
  .out_prime_count(out_prime_count)
);
`default_nettype wire

// ----- tb/tb_sorted_set_three_order_reader.sv -----
// Self-checking testbench for the sorted set with prime filter.
module tb_sorted_set_three_order_reader;
  timeunit 1ns;
  timeprecision 1ps;

  // Insert of a large prime runs a long trial division, so the stall limit sits several
  // times above the longest such run.
  localparam int STALL_LIMIT = 8_000_000;
  localparam int SET_DEPTH   = 64;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
    logic [5:0]  position;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [6:0]  element_count;
    logic [6:0]  prime_count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [31:0] in_value = '0;
  logic [5:0]  in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_read_value;
  logic [6:0]  out_element_count;
  logic [6:0]  out_prime_count;

  always #4 clk = ~clk;

  sorted_set_three_order_reader #(.DEPTH(SET_DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_read_value(out_read_value), .out_element_count(out_element_count),
    .out_prime_count(out_prime_count)
  );

  // Shadow copy of the set, kept in ascending order.
  logic signed [31:0] shadow_values [SET_DEPTH];
  logic               shadow_prime  [SET_DEPTH];
  int                 shadow_count  = 0;
  int                 shadow_primes = 0;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       error_count = 0;
  int       accepted_requests = 0;
  int       checked_answers = 0;
  int       total_requests = 0;
  bit       stimulus_done = 1'b0;

  function automatic void queue_request(request_t rq);
    pending_requests.insert(pending_requests.size(), rq);
  endfunction

  function automatic void queue_answer(answer_t ans);
    expected_answers.insert(expected_answers.size(), ans);
  endfunction

  // Trial division on a 64-bit square so large values do not overflow.
  function automatic bit is_prime(logic signed [31:0] v);
    longint n;
    longint d;
    n = longint'(v);
    if (n <= 1) return 1'b0;
    for (d = 2; d * d <= n; d++)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one request to the shadow set and return the answer it should give.
  function automatic answer_t apply_request(request_t rq);
    answer_t            ans;
    logic signed [31:0] v;
    int                 k;
    int                 rank;
    int                 p;
    bit                 flag;
    v = rq.value;
    p = int'(rq.position);
    ans = '0;
    ans.status = sstor_pkg::ST_OK;
    k = 0;
    while (k < shadow_count && shadow_values[k] < v) k++;
    case (rq.command)
      sstor_pkg::CMD_INSERT: begin
        if (k < shadow_count && shadow_values[k] == v) begin
          ans.status = sstor_pkg::ST_DUP;
        end else if (shadow_count >= SET_DEPTH) begin
          ans.status = sstor_pkg::ST_FULL;
        end else begin
          flag = is_prime(v);
          for (int i = shadow_count; i > k; i--) begin
            shadow_values[i] = shadow_values[i-1];
            shadow_prime[i]  = shadow_prime[i-1];
          end
          shadow_values[k] = v;
          shadow_prime[k]  = flag;
          shadow_count++;
          if (flag) shadow_primes++;
        end
      end
      sstor_pkg::CMD_REMOVE: begin
        if (k < shadow_count && shadow_values[k] == v) begin
          if (shadow_prime[k]) shadow_primes--;
          for (int i = k; i + 1 < shadow_count; i++) begin
            shadow_values[i] = shadow_values[i+1];
            shadow_prime[i]  = shadow_prime[i+1];
          end
          shadow_count--;
        end else begin
          ans.status = sstor_pkg::ST_NOTFOUND;
        end
      end
      sstor_pkg::CMD_READ_ASC: begin
        if (p < shadow_count) ans.read_value = shadow_values[p];
        else ans.status = sstor_pkg::ST_RANGE;
      end
      sstor_pkg::CMD_READ_SIDE: begin
        if (p >= shadow_count) ans.status = sstor_pkg::ST_RANGE;
        else if (p % 2 == 0) ans.read_value = shadow_values[p/2];
        else ans.read_value = shadow_values[shadow_count - 1 - p/2];
      end
      sstor_pkg::CMD_READ_PRIME: begin
        if (p < shadow_primes) begin
          rank = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_prime[i]) begin
              if (rank == p) begin
                ans.read_value = shadow_values[i];
                break;
              end
              rank++;
            end
          end
        end else begin
          ans.status = sstor_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    ans.element_count = shadow_count[6:0];
    ans.prime_count   = shadow_primes[6:0];
    return ans;
  endfunction

  function automatic request_t make_request(logic [2:0] c, logic [31:0] v, logic [5:0] p);
    request_t rq;
    rq.command  = c;
    rq.value    = v;
    rq.position = p;
    return rq;
  endfunction

  // Mostly small values keep trial division short; a few wide values exercise every bit
  // but are kept even so they stay cheap.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 60) - 20;
    if (r < 8) return $urandom_range(0, 1000);
    return $urandom & 32'hFFFF_FFFE;
  endfunction

  // Fill the request queue: directed corner cases first, then a random mix.
  initial begin : fill_requests
    int r;
    int directed_total;
    // Empty-set reads and a remove, then the minimum and the largest even value, and the primality edges.
    queue_request(make_request(sstor_pkg::CMD_READ_ASC, 32'd0, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_READ_SIDE, 32'd0, 6'd63));
    queue_request(make_request(sstor_pkg::CMD_READ_PRIME, 32'd0, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_REMOVE, 32'd5, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'h8000_0000, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'h7FFF_FFFE, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd0, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd1, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd2, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd3, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd4, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'hFFFF_FFF9, 6'd0));  // -7
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd97, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd2, 6'd0));          // duplicate
    for (int p = 0; p < 4; p++)
      queue_request(make_request(sstor_pkg::CMD_READ_SIDE, 32'd0, p[5:0]));
    queue_request(make_request(sstor_pkg::CMD_READ_ASC, 32'hFFFF_FFFF, 6'd8));
    queue_request(make_request(sstor_pkg::CMD_READ_PRIME, 32'd0, 6'd2));
    queue_request(make_request(sstor_pkg::CMD_READ_PRIME, 32'd0, 6'd3));      // past primes
    queue_request(make_request(sstor_pkg::CMD_REMOVE, 32'd2, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_QUERY, 32'd0, 6'd0));
    queue_request(make_request(3'd6, 32'h1234_5678, 6'd21));
    queue_request(make_request(3'd7, 32'hEDCB_A987, 6'd42));
    directed_total = pending_requests.size();

    // Hold the sender until every directed answer is back.
    wait (checked_answers == directed_total);

    // Fill the set to capacity with cheap even values and probe the full store.
    for (int i = 0; i < SET_DEPTH; i++)
      queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd1000 + 2 * i, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd5000, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_INSERT, 32'd1000, 6'd0));
    queue_request(make_request(sstor_pkg::CMD_READ_ASC, 32'd0, 6'd63));
    queue_request(make_request(sstor_pkg::CMD_READ_SIDE, 32'd0, 6'd63));
    queue_request(make_request(sstor_pkg::CMD_READ_PRIME, 32'd0, 6'd63));
    for (int i = 0; i < SET_DEPTH; i += 8)
      queue_request(make_request(sstor_pkg::CMD_REMOVE, 32'd1000 + 2 * i, 6'd0));

    // Short random mix weighted towards inserts and reads.
    for (int n = 0; n < 10; n++) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2: queue_request(make_request(sstor_pkg::CMD_INSERT, pick_value(), 6'd0));
        3:       queue_request(make_request(sstor_pkg::CMD_REMOVE, pick_value(), 6'd0));
        4:       queue_request(make_request(sstor_pkg::CMD_READ_ASC, $urandom,
                                            6'($urandom_range(0, 63))));
        5:       queue_request(make_request(sstor_pkg::CMD_READ_SIDE, $urandom,
                                            6'($urandom_range(0, 63))));
        6:       queue_request(make_request(sstor_pkg::CMD_READ_PRIME, $urandom,
                                            6'($urandom_range(0, 15))));
        7:       queue_request(make_request(sstor_pkg::CMD_QUERY, $urandom, 6'($urandom)));
        8:       queue_request(make_request(3'($urandom_range(6, 7)), $urandom,
                                            6'($urandom)));
        default: queue_request(make_request(sstor_pkg::CMD_READ_SIDE, 32'd0,
                                            6'($urandom_range(0, 7))));
      endcase
    end
    total_requests = directed_total + pending_requests.size();
    stimulus_done = 1'b1;
  end

  // Driver: draw a gap per request, hold each request until it is taken.
  bit accept_seen = 1'b0;
  bit answer_seen = 1'b0;
  int send_gap = 0;
  int recv_wait = 0;
  int recv_draw = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accept_seen) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          request_t rq;
          rq = pending_requests.pop_front();
          in_command  <= rq.command;
          in_value    <= rq.value;
          in_position <= rq.position;
          in_valid    <= 1'b1;
          send_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Receiver: draw a wait per answer, then stay ready until the next one is taken.
      if (answer_seen) begin
        recv_draw = $urandom_range(0, 17);
        recv_wait <= recv_draw;
        out_ready <= (recv_draw == 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= (recv_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted answer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    accept_seen <= rst_n && in_valid && in_ready;
    answer_seen <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                     0 : idle_cycles + 1;
      if (in_valid && in_ready) begin
        queue_answer(apply_request({in_command, in_value, in_position}));
        accepted_requests <= accepted_requests + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("answer with nothing outstanding: status %0d", out_status);
          error_count++;
        end else begin
          answer_t exp_ans;
          exp_ans = expected_answers.pop_front();
          checked_answers <= checked_answers + 1;
          if (out_status !== exp_ans.status) begin
            $error("status: expected %0d, got %0d", exp_ans.status, out_status);
            error_count++;
          end
          if (out_read_value !== exp_ans.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(exp_ans.read_value), $signed(out_read_value));
            error_count++;
          end
          if (out_element_count !== exp_ans.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   exp_ans.element_count, out_element_count);
            error_count++;
          end
          if (out_prime_count !== exp_ans.prime_count) begin
            $error("prime_count: expected %0d, got %0d",
                   exp_ans.prime_count, out_prime_count);
            error_count++;
          end
        end
      end
    end
  end

  // Reset, then wait for the drain or the watchdog.
  initial begin : run_control
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait ((stimulus_done && checked_answers == total_requests)
          || idle_cycles >= STALL_LIMIT);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
    end else begin
      repeat (200) @(posedge clk);
      if (out_valid) begin
        $error("unexpected answer after drain");
        error_count++;
      end
      $display("Covered %0d requests and %0d answers: all six commands, unused codes,",
               accepted_requests, checked_answers);
      $display("duplicates, absent removes, full store and out-of-range reads.");
      if (error_count == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/sstor_pkg.sv
design/sstor_cell.sv
design/sstor_prime.sv
design/sorted_set_three_order_reader.sv
design/sstor_checker.sv
tb/tb_sorted_set_three_order_reader.sv
